@@ rtl/core/bbnm_pkg.sv @@
package bbnm_pkg;

    // Field widths sized for the largest supported MAX_WIDTH / MAX_RADIUS.
    localparam int PIX_W       = 8;
    localparam int WORD_W      = 32;
    localparam int ROW_W       = 16;
    localparam int COL_W       = 13;
    localparam int WID_W       = 14;
    localparam int CFGW_W      = 11;
    localparam int RAD_W       = 3;
    localparam int TAP_W       = RAD_W + 1;
    localparam int RING_W      = 4;
    localparam int SUM_W       = 16;
    localparam int PROD_W      = 41;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 3;
    localparam int DEF_CHANNELS   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [ROW_W-1:0] height;
        logic [RAD_W-1:0] radius;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] pixel;
        logic [COL_W-1:0]  cx;
        logic [ROW_W-1:0]  cy;
        logic [RING_W-1:0] ring;
        logic              release_any;
        logic [COL_W-1:0]  x_lo;
        logic [COL_W-1:0]  x_hi;
        logic [ROW_W-1:0]  y_lo;
        logic [ROW_W-1:0]  y_hi;
    } job_t;

    // ceil(2^24 / (2r+1)^2): exact quotient for sums below 2^15
    function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
        logic [RECIP_W-1:0] m;
        unique case (r)
            3'd0: m = 25'd16777216;
            3'd1: m = 25'd1864136;
            3'd2: m = 25'd671089;
            3'd3: m = 25'd342393;
            3'd4: m = 25'd207127;
            3'd5: m = 25'd138655;
            3'd6: m = 25'd99274;
            3'd7: m = 25'd74566;
            default: m = 25'd16777216;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/bbnm_front.sv @@
module bbnm_front
    import bbnm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [WORD_W-1:0]     pixel,
    input  logic                  q_full,
    output logic                  q_push,
    output job_t                  q_job,
    output cfg_t                  cfg
);

    localparam int RING = 2 * MAX_RADIUS + 1;

    logic [CFGW_W-1:0] width_reg;
    logic [ROW_W-1:0]  height_reg;
    logic [1:0]        radius_reg;
    logic [COL_W-1:0]  cx_reg, cx_next;
    logic [ROW_W-1:0]  cy_reg, cy_next;
    logic [RING_W-1:0] ring_reg, ring_next;

    logic [WID_W-1:0] w;
    logic [ROW_W-1:0] h;
    logic [RAD_W-1:0] r;
    logic             col_rel, row_rel;
    logic [COL_W-1:0] x_lo, x_hi;
    logic [ROW_W-1:0] y_lo, y_hi;
    logic             accept;

    always_comb
    begin
        if (width_reg == '0)
            w = WID_W'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w = WID_W'(MAX_WIDTH);
        else
            w = WID_W'(width_reg);
        h = (height_reg == '0) ? ROW_W'(1) : height_reg;
        r = (int'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_reg);
    end

    assign cfg = '{width: w, height: h, radius: r};

    // which output columns and rows this input completes
    always_comb
    begin
        col_rel = 1'b0;
        x_lo    = '0;
        x_hi    = cx_reg;
        if (WID_W'(cx_reg) == w - WID_W'(1))
        begin
            col_rel = 1'b1;
            x_lo    = (cx_reg >= COL_W'(r)) ? cx_reg - COL_W'(r) : '0;
        end
        else if (cx_reg >= COL_W'(r))
        begin
            col_rel = 1'b1;
            x_lo    = cx_reg - COL_W'(r);
            x_hi    = x_lo;
        end

        row_rel = 1'b0;
        y_lo    = '0;
        y_hi    = cy_reg;
        if (cy_reg == h - ROW_W'(1))
        begin
            row_rel = 1'b1;
            y_lo    = (cy_reg >= ROW_W'(r)) ? cy_reg - ROW_W'(r) : '0;
        end
        else if (cy_reg >= ROW_W'(r))
        begin
            row_rel = 1'b1;
            y_lo    = cy_reg - ROW_W'(r);
            y_hi    = y_lo;
        end
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;
    assign q_job    = '{pixel: pixel, cx: cx_reg, cy: cy_reg, ring: ring_reg,
                        release_any: col_rel && row_rel,
                        x_lo: x_lo, x_hi: x_hi, y_lo: y_lo, y_hi: y_hi};

    always_comb
    begin
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        ring_next = ring_reg;
        if (accept)
        begin
            if (WID_W'(cx_reg) == w - WID_W'(1))
            begin
                cx_next = '0;
                if (cy_reg == h - ROW_W'(1))
                begin
                    cy_next   = '0;
                    ring_next = '0;
                end
                else
                begin
                    cy_next   = cy_reg + ROW_W'(1);
                    ring_next = (int'(ring_reg) == RING - 1) ? '0 : ring_reg + RING_W'(1);
                end
            end
            else
                cx_next = cx_reg + COL_W'(1);
        end
        if (cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                       cfg_index == REG_RADIUS))
        begin
            cx_next   = '0;
            cy_next   = '0;
            ring_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFGW_W'(1024);
            height_reg <= ROW_W'(1024);
            radius_reg <= 2'd1;
            cx_reg     <= '0;
            cy_reg     <= '0;
            ring_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WIDTH:  width_reg  <= cfg_data[CFGW_W-1:0];
                    REG_HEIGHT: height_reg <= cfg_data[ROW_W-1:0];
                    REG_RADIUS: radius_reg <= cfg_data[1:0];
                    default:    ;
                endcase
            end
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            ring_reg <= ring_next;
        end
    end

endmodule

@@ rtl/core/bbnm_queue.sv @@
module bbnm_queue
    import bbnm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ rtl/core/bbnm_back.sv @@
module bbnm_back
    import bbnm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int CHANNELS   = DEF_CHANNELS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              job_valid,
    input  job_t              job,
    output logic              job_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PIX_W-1:0]  out_pix [4],
    output logic              end_of_frame,
    output logic              last_of_run
);

    localparam int RING  = 2 * MAX_RADIUS + 1;
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_TAP   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_RND   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    logic [2:0]       state_reg, state_next;
    job_t             job_reg;
    logic [COL_W-1:0] ox_reg, ox_next;
    logic [ROW_W-1:0] oy_reg, oy_next;
    logic [TAP_W-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic             rv_reg, rv_next;
    logic signed [SUM_W-1:0]  acc_reg  [4];
    logic [PROD_W-1:0]        prod_reg [4];
    logic [3:0]               neg_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_reg [4];
    logic             eof_reg, lor_reg;

    logic [TAP_W-1:0] span;
    logic signed [ROW_W+1:0] ys;
    logic signed [COL_W+1:0] xs;
    logic [ROW_W-1:0]  yy, row_gap;
    logic [COL_W-1:0]  xx;
    logic [RING_W-1:0] ring_sel;
    logic [AW-1:0]     raddr, waddr;
    logic              out_last;

    assign span = TAP_W'({cfg.radius, 1'b0});

    // clamped tap coordinates and the ring slot that holds row yy
    always_comb
    begin
        ys = signed'({2'b00, oy_reg}) + signed'((ROW_W+2)'(ty_reg))
             - signed'((ROW_W+2)'(cfg.radius));
        xs = signed'({2'b00, ox_reg}) + signed'((COL_W+2)'(tx_reg))
             - signed'((COL_W+2)'(cfg.radius));
        if (ys < 0)
            yy = '0;
        else if (ys > signed'({2'b00, cfg.height - ROW_W'(1)}))
            yy = cfg.height - ROW_W'(1);
        else
            yy = ys[ROW_W-1:0];
        if (xs < 0)
            xx = '0;
        else if (xs > signed'((COL_W+2)'(cfg.width - WID_W'(1))))
            xx = COL_W'(cfg.width - WID_W'(1));
        else
            xx = xs[COL_W-1:0];
        row_gap = job_reg.cy - yy;
        if (job_reg.ring >= row_gap[RING_W-1:0])
            ring_sel = job_reg.ring - row_gap[RING_W-1:0];
        else
            ring_sel = job_reg.ring + RING_W'(RING) - row_gap[RING_W-1:0];
        raddr = AW'(ring_sel) * AW'(MAX_WIDTH) + AW'(xx);
        waddr = AW'(job_reg.ring) * AW'(MAX_WIDTH) + AW'(job_reg.cx);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
            mem[waddr] <= job_reg.pixel;
        rdata_reg <= mem[raddr];
    end

    assign job_pop  = (state_reg == S_IDLE) && job_valid;
    assign out_last = (ox_reg == job_reg.x_hi) && (oy_reg == job_reg.y_hi);

    always_comb
    begin
        state_next = state_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        rv_next    = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (job_valid)
                    state_next = S_WRITE;
            S_WRITE:
            begin
                ox_next = job_reg.x_lo;
                oy_next = job_reg.y_lo;
                tx_next = '0;
                ty_next = '0;
                state_next = job_reg.release_any ? S_TAP : S_IDLE;
            end
            S_TAP:
            begin
                rv_next = 1'b1;
                if (tx_reg == span)
                begin
                    tx_next = '0;
                    ty_next = ty_reg + TAP_W'(1);
                    if (ty_reg == span)
                    begin
                        ty_next    = '0;
                        state_next = S_DRAIN;
                    end
                end
                else
                    tx_next = tx_reg + TAP_W'(1);
            end
            S_DRAIN: state_next = S_MUL;
            S_MUL:   state_next = S_RND;
            S_RND:   state_next = S_OUT;
            S_OUT:
                if (out_ready)
                begin
                    if (out_last)
                        state_next = S_IDLE;
                    else
                    begin
                        state_next = S_TAP;
                        if (ox_reg == job_reg.x_hi)
                        begin
                            ox_next = job_reg.x_lo;
                            oy_next = oy_reg + ROW_W'(1);
                        end
                        else
                            ox_next = ox_reg + COL_W'(1);
                    end
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            tx_reg        <= '0;
            ty_reg        <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            tx_reg    <= tx_next;
            ty_reg    <= ty_next;
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            if (state_reg == S_RND)
                out_valid_reg <= 1'b1;
            else if (state_reg == S_OUT && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
            job_reg <= job;
        for (int c = 0; c < 4; c++)
        begin
            if (state_reg == S_WRITE || state_reg == S_OUT)
                acc_reg[c] <= '0;
            else if (rv_reg)
                acc_reg[c] <= acc_reg[c]
                    + SUM_W'(signed'(rdata_reg[c*PIX_W +: PIX_W]));
            if (state_reg == S_MUL)
            begin
                neg_reg[c]  <= acc_reg[c][SUM_W-1];
                // |S| + (n-1)/2, then times ceil(2^24/n)
                prod_reg[c] <= PROD_W'((acc_reg[c][SUM_W-1] ? SUM_W'(-acc_reg[c])
                                        : SUM_W'(acc_reg[c]))
                                       + SUM_W'({cfg.radius, 1'b0})
                                         * SUM_W'(cfg.radius + RAD_W'(1)))
                               * PROD_W'(recip(cfg.radius));
            end
            if (state_reg == S_RND)
            begin
                if (c >= CHANNELS)
                    out_reg[c] <= '0;
                else if (neg_reg[c])
                    out_reg[c] <= PIX_W'(-prod_reg[c][RECIP_SHIFT +: PIX_W+1]);
                else if (prod_reg[c][RECIP_SHIFT +: PIX_W+1] > (PIX_W+1)'(127))
                    out_reg[c] <= PIX_W'(127);
                else
                    out_reg[c] <= prod_reg[c][RECIP_SHIFT +: PIX_W];
            end
        end
        if (state_reg == S_RND)
        begin
            eof_reg <= (oy_reg == cfg.height - ROW_W'(1))
                       && (WID_W'(ox_reg) == cfg.width - WID_W'(1));
            lor_reg <= out_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_pix      = out_reg;
    assign end_of_frame = eof_reg;
    assign last_of_run  = lor_reg;

    a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_OUT)
        else $error("result shown outside output state");

    a_read_follows_tap: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> $past(state_reg) == S_TAP)
        else $error("read data used without a tap issue");

    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TAP |-> (tx_reg <= span && ty_reg <= span))
        else $error("tap counter beyond window");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> state_reg == S_WRITE)
        else $error("request taken without store write");

endmodule

@@ rtl/core/box_blur_normal_map_unit.sv @@
// Sequence: a taken request first writes its pixel into the row store; each result it
// releases then reads its (2r+1)^2 window taps through the single read port of the row
// store, is scaled and rounded, and is held until the out_ready handshake.
// The back end takes a new request only when done with the previous one (its store
// write and every result it releases); the two-entry queue in front buffers requests.
// Reset: asynchronous, active low; clears positions, queue and control, loads
// register defaults; the row store is not cleared.
module box_blur_normal_map_unit
    import bbnm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int CHANNELS   = DEF_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [7:0]     chan_a,
    input  logic signed [7:0]     chan_b,
    input  logic signed [7:0]     chan_c,
    input  logic signed [7:0]     chan_d,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [7:0]     out_a,
    output logic signed [7:0]     out_b,
    output logic signed [7:0]     out_c,
    output logic signed [7:0]     out_d,
    output logic                  end_of_frame,
    output logic                  last_of_run
);

    cfg_t             cfg;
    job_t             push_job, head_job;
    logic             push, full, pop, head_valid;
    logic [PIX_W-1:0] out_pix [4];

    bbnm_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .pixel({chan_d, chan_c, chan_b, chan_a}),
        .q_full(full), .q_push(push), .q_job(push_job), .cfg(cfg)
    );

    bbnm_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_job(push_job), .full(full),
        .pop(pop), .head_valid(head_valid), .head_job(head_job)
    );

    bbnm_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS), .CHANNELS(CHANNELS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .job_valid(head_valid), .job(head_job), .job_pop(pop),
        .out_valid(out_valid), .out_ready(out_ready), .out_pix(out_pix),
        .end_of_frame(end_of_frame), .last_of_run(last_of_run)
    );

    assign out_a = signed'(out_pix[0]);
    assign out_b = signed'(out_pix[1]);
    assign out_c = signed'(out_pix[2]);
    assign out_d = signed'(out_pix[3]);

endmodule
